// ----- src/cli_pkg.sv -----
package cli_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;

    localparam int DIFF_W = COORD_BITS + 1;          // b - a, a - c
    localparam int HALF_W = DIFF_W;                   // split width for wide products
    localparam int PROD_W = 2 * DIFF_W;               // product of two differences
    localparam int D_W    = PROD_W;                   // |b - a|^2, unsigned
    localparam int PQ_W   = PROD_W + 1;               // P and Q, signed
    localparam int MAG_W  = 2 * HALF_W;               // |P|, |Q|
    localparam int SQR_W  = 2 * MAG_W;                // P*P, Q*D magnitudes
    localparam int DEL_W  = SQR_W + 1;                // discriminant, signed
    localparam int RT_W   = 2 * COORD_BITS + FRAC_BITS; // root bits
    localparam int X_W    = 2 * RT_W;                 // radicand
    localparam int NPF_W  = PQ_W + FRAC_BITS;         // -P scaled, signed
    localparam int NUM_W  = NPF_W + 1;                // -P*2^f +/- S, signed
    localparam int QT_W   = COORD_BITS + 1;           // quotient bits before clamp
    localparam int WIDE_W = D_W + QT_W;
    localparam int CMP_W  = (WIDE_W > NUM_W) ? WIDE_W : NUM_W;

    localparam logic [1:0] HITS_NONE    = 2'd0;
    localparam logic [1:0] HITS_TANGENT = 2'd1;
    localparam logic [1:0] HITS_TWO     = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic        [COORD_BITS-2:0] radius;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } t_query;

    typedef struct packed {
        logic [1:0]                   hit_count;
        logic signed [COORD_BITS-1:0] t_first;
        logic signed [COORD_BITS-1:0] t_second;
        logic                         degenerate;
        logic                         saturated;
    } t_result;

    // carried alongside the discriminant and root
    typedef struct packed {
        logic [1:0]              hits;
        logic                    degen;
        logic [D_W-1:0]          d;
        logic signed [NPF_W-1:0] npf;
    } t_side;

    typedef struct packed {
        logic [1:0]     hits;
        logic           degen;
        logic [D_W-1:0] d;
    } t_nside;

    typedef struct packed {
        logic [RT_W+1:0] rem;
        logic [RT_W-1:0] root;
        logic [X_W-1:0]  x;
    } t_sq;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QT_W-1:0]  q;
        logic             neg;
        logic             ovf;
    } t_lane;

    typedef struct packed {
        logic [QT_W:0] qq;
        logic          neg;
        logic          ovf;
    } t_fin;

    typedef struct packed {
        logic                         sat;
        logic signed [COORD_BITS-1:0] val;
    } t_clamp;

endpackage

// ----- src/circle_line_intersection.sv -----
// Line-circle crossing in signed fixed point, one word taken every cycle; busy never rises.
// Each taken word passes 126 register stages before o_done strobes; the stage count is mostly set by
// the 80 stage square root and the 33 stage quotient of each crossing,
// behind seven stages of differences, products and the discriminant.
// Synchronous active-low reset clears the valid bits; the receiver cannot stall results.
module circle_line_intersection import cli_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_query  i_query,
    output logic    o_done,
    output t_result o_result
);

    function automatic t_sq sqrt_step(input t_sq s);
        logic [RT_W+1:0] rem;
        logic [RT_W+1:0] trial;
        t_sq             o;
        rem   = {s.rem[RT_W-1:0], s.x[X_W-1 -: 2]};
        trial = {s.root, 2'b01};
        o.x   = s.x << 2;
        if (rem >= trial) begin
            o.rem  = rem - trial;
            o.root = {s.root[RT_W-2:0], 1'b1};
        end else begin
            o.rem  = rem;
            o.root = {s.root[RT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_lane div_step(input t_lane l, input logic [D_W-1:0] d, input int k);
        logic [CMP_W-1:0] dsh;
        logic [CMP_W-1:0] rw;
        t_lane            o;
        dsh   = CMP_W'(d) << k;
        rw    = CMP_W'(l.rem);
        o     = l;
        if (rw >= dsh) begin
            o.rem = NUM_W'(rw - dsh);
            o.q   = {l.q[QT_W-2:0], 1'b1};
        end else begin
            o.q   = {l.q[QT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_clamp clamp_t(input t_fin f);
        t_clamp c;
        c.sat = 1'b0;
        c.val = '0;
        if (f.neg) begin
            if (f.ovf || f.qq > {3'b001, {(COORD_BITS-1){1'b0}}}) begin
                c.sat = 1'b1;
                c.val = {1'b1, {(COORD_BITS-1){1'b0}}};
            end else begin
                c.val = -f.qq[COORD_BITS-1:0];
            end
        end else begin
            if (f.ovf || f.qq > {3'b000, {(COORD_BITS-1){1'b1}}}) begin
                c.sat = 1'b1;
                c.val = {1'b0, {(COORD_BITS-1){1'b1}}};
            end else begin
                c.val = f.qq[COORD_BITS-1:0];
            end
        end
        return c;
    endfunction

    logic w_accept;
    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    // stage 1: differences
    logic r_v1;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_ex, r_ey;
    logic [COORD_BITS-2:0]    r_r1;

    // stage 2: products
    logic r_v2;
    logic signed [PROD_W-1:0]   r_pdx2, r_pdy2, r_pex, r_pey, r_pex2, r_pey2;
    logic [2*COORD_BITS-3:0]    r_prr;

    // stage 3: D, P, Q
    logic r_v3;
    logic [D_W-1:0]         r_d3;
    logic signed [PQ_W-1:0] r_p3, r_q3;

    // stage 4: magnitudes
    logic r_v4;
    logic [MAG_W-1:0] r_pm4, r_qm4;
    logic             r_qneg4;
    t_side            r_side4;

    // stage 5: partial products
    logic r_v5;
    logic [PROD_W-1:0] r_pp_hh, r_pp_hl, r_pp_ll, r_qd_hh, r_qd_hl, r_qd_lh, r_qd_ll;
    logic              r_qneg5;
    t_side             r_side5;

    // stage 6: wide squares
    logic r_v6;
    logic [SQR_W-1:0] r_pp6, r_qd6;
    logic             r_qneg6;
    t_side            r_side6;

    // stage 7: discriminant
    logic r_v7;
    logic signed [DEL_W-1:0] r_del7;
    t_side                   r_side7;

    // square root pipeline, entry 0 is the load stage
    logic  r_sq_v    [0:RT_W];
    t_sq   r_sq      [0:RT_W];
    t_side r_sq_side [0:RT_W];

    // crossing numerators and magnitudes
    logic r_n1_v, r_n2_v;
    logic [NUM_W-1:0] r_num [0:1];
    logic [NUM_W-1:0] r_mag [0:1];
    logic             r_neg [0:1];
    t_nside           r_n1_side, r_n2_side;

    // quotient pipeline, entry 0 holds the overflow check
    logic   r_dv_v    [0:QT_W];
    t_lane  r_dv      [0:QT_W][0:1];
    t_nside r_dv_side [0:QT_W];

    logic   r_f_v;
    t_fin   r_fin [0:1];
    t_nside r_f_side;

    logic    r_o_v;
    t_result r_res;

    logic signed [DEL_W-1:0] n_del;
    logic [1:0]              n_hits;
    t_clamp                  w_c1, w_c2;
    t_result                 n_res;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
            r_v7   <= 1'b0;
            r_n1_v <= 1'b0;
            r_n2_v <= 1'b0;
            r_f_v  <= 1'b0;
            r_o_v  <= 1'b0;
            for (int j = 0; j <= RT_W; j++) r_sq_v[j] <= 1'b0;
            for (int j = 0; j <= QT_W; j++) r_dv_v[j] <= 1'b0;
        end else begin
            r_v1      <= w_accept;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_v5      <= r_v4;
            r_v6      <= r_v5;
            r_v7      <= r_v6;
            r_sq_v[0] <= r_v7;
            for (int j = 0; j < RT_W; j++) r_sq_v[j+1] <= r_sq_v[j];
            r_n1_v    <= r_sq_v[RT_W];
            r_n2_v    <= r_n1_v;
            r_dv_v[0] <= r_n2_v;
            for (int j = 0; j < QT_W; j++) r_dv_v[j+1] <= r_dv_v[j];
            r_f_v     <= r_dv_v[QT_W];
            r_o_v     <= r_f_v;
        end
    end

    // front end: differences, products, sums, magnitudes, wide squares and the discriminant
    always_ff @(posedge i_clk) begin
        r_dx <= {i_query.end_x[COORD_BITS-1], i_query.end_x}
              - {i_query.start_x[COORD_BITS-1], i_query.start_x};
        r_dy <= {i_query.end_y[COORD_BITS-1], i_query.end_y}
              - {i_query.start_y[COORD_BITS-1], i_query.start_y};
        r_ex <= {i_query.start_x[COORD_BITS-1], i_query.start_x}
              - {i_query.center_x[COORD_BITS-1], i_query.center_x};
        r_ey <= {i_query.start_y[COORD_BITS-1], i_query.start_y}
              - {i_query.center_y[COORD_BITS-1], i_query.center_y};
        r_r1 <= i_query.radius;

        r_pdx2 <= r_dx * r_dx;
        r_pdy2 <= r_dy * r_dy;
        r_pex  <= r_ex * r_dx;
        r_pey  <= r_ey * r_dy;
        r_pex2 <= r_ex * r_ex;
        r_pey2 <= r_ey * r_ey;
        r_prr  <= r_r1 * r_r1;

        r_d3 <= {1'b0, r_pdx2[PROD_W-2:0]} + {1'b0, r_pdy2[PROD_W-2:0]};
        r_p3 <= {r_pex[PROD_W-1], r_pex} + {r_pey[PROD_W-1], r_pey};
        r_q3 <= {2'b00, r_pex2[PROD_W-2:0]} + {2'b00, r_pey2[PROD_W-2:0]} - PQ_W'(r_prr);

        r_pm4         <= r_p3[PQ_W-1] ? MAG_W'(-r_p3) : MAG_W'(r_p3);
        r_qm4         <= r_q3[PQ_W-1] ? MAG_W'(-r_q3) : MAG_W'(r_q3);
        r_qneg4       <= r_q3[PQ_W-1];
        r_side4.hits  <= HITS_NONE;
        r_side4.degen <= (r_d3 == '0);
        r_side4.d     <= r_d3;
        r_side4.npf   <= -{r_p3, {FRAC_BITS{1'b0}}};

        r_pp_hh <= r_pm4[MAG_W-1:HALF_W] * r_pm4[MAG_W-1:HALF_W];
        r_pp_hl <= r_pm4[MAG_W-1:HALF_W] * r_pm4[HALF_W-1:0];
        r_pp_ll <= r_pm4[HALF_W-1:0] * r_pm4[HALF_W-1:0];
        r_qd_hh <= r_qm4[MAG_W-1:HALF_W] * r_side4.d[D_W-1:HALF_W];
        r_qd_hl <= r_qm4[MAG_W-1:HALF_W] * r_side4.d[HALF_W-1:0];
        r_qd_lh <= r_qm4[HALF_W-1:0] * r_side4.d[D_W-1:HALF_W];
        r_qd_ll <= r_qm4[HALF_W-1:0] * r_side4.d[HALF_W-1:0];
        r_qneg5 <= r_qneg4;
        r_side5 <= r_side4;

        r_pp6 <= (SQR_W'(r_pp_hh) << MAG_W) + (SQR_W'(r_pp_hl) << (HALF_W + 1))
               + SQR_W'(r_pp_ll);
        r_qd6 <= (SQR_W'(r_qd_hh) << MAG_W)
               + ((SQR_W'(r_qd_hl) + SQR_W'(r_qd_lh)) << HALF_W) + SQR_W'(r_qd_ll);
        r_qneg6 <= r_qneg5;
        r_side6 <= r_side5;

        r_del7  <= n_del;
        r_side7 <= r_side6;
    end

    assign n_del = r_qneg6 ? ({1'b0, r_pp6} + {1'b0, r_qd6}) : ({1'b0, r_pp6} - {1'b0, r_qd6});

    always_comb begin
        priority if (r_del7[DEL_W-1]) begin
            n_hits = HITS_NONE;
        end else if (r_del7 == '0) begin
            n_hits = HITS_TANGENT;
        end else begin
            n_hits = HITS_TWO;
        end
    end

    // square root: two radicand bits per stage
    always_ff @(posedge i_clk) begin
        r_sq[0].rem  <= '0;
        r_sq[0].root <= '0;
        r_sq[0].x    <= {r_del7[4*COORD_BITS-1:0], {(2*FRAC_BITS){1'b0}}};
        r_sq_side[0] <= '{hits: n_hits, degen: r_side7.degen, d: r_side7.d, npf: r_side7.npf};
        for (int j = 0; j < RT_W; j++) begin
            r_sq[j+1]      <= sqrt_step(r_sq[j]);
            r_sq_side[j+1] <= r_sq_side[j];
        end
    end

    // numerators, magnitudes, overflow check, then one quotient bit per stage
    always_ff @(posedge i_clk) begin
        r_num[0]  <= {r_sq_side[RT_W].npf[NPF_W-1], r_sq_side[RT_W].npf}
                   + NUM_W'(r_sq[RT_W].root);
        r_num[1]  <= {r_sq_side[RT_W].npf[NPF_W-1], r_sq_side[RT_W].npf}
                   - NUM_W'(r_sq[RT_W].root);
        r_n1_side <= '{hits: r_sq_side[RT_W].hits, degen: r_sq_side[RT_W].degen,
                       d: r_sq_side[RT_W].d};

        for (int l = 0; l < 2; l++) begin
            r_neg[l] <= r_num[l][NUM_W-1];
            r_mag[l] <= r_num[l][NUM_W-1] ? -r_num[l] : r_num[l];
        end
        r_n2_side <= r_n1_side;

        for (int l = 0; l < 2; l++) begin
            r_dv[0][l].rem <= r_mag[l];
            r_dv[0][l].q   <= '0;
            r_dv[0][l].neg <= r_neg[l];
            r_dv[0][l].ovf <= CMP_W'(r_mag[l]) >= (CMP_W'(r_n2_side.d) << QT_W);
        end
        r_dv_side[0] <= r_n2_side;

        for (int j = 0; j < QT_W; j++) begin
            for (int l = 0; l < 2; l++) begin
                r_dv[j+1][l] <= div_step(r_dv[j][l], r_dv_side[j].d, QT_W - 1 - j);
            end
            r_dv_side[j+1] <= r_dv_side[j];
        end

        // floor for negative numerators
        for (int l = 0; l < 2; l++) begin
            r_fin[l].qq  <= {1'b0, r_dv[QT_W][l].q}
                          + (QT_W + 1)'(r_dv[QT_W][l].neg && (r_dv[QT_W][l].rem != '0));
            r_fin[l].neg <= r_dv[QT_W][l].neg;
            r_fin[l].ovf <= r_dv[QT_W][l].ovf;
        end
        r_f_side <= r_dv_side[QT_W];

        r_res <= n_res;
    end

    assign w_c1 = clamp_t(r_fin[0]);
    assign w_c2 = clamp_t(r_fin[1]);

    always_comb begin
        n_res            = '0;
        n_res.degenerate = r_f_side.degen;
        if (!r_f_side.degen) begin
            unique case (r_f_side.hits)
                HITS_TANGENT: begin
                    n_res.hit_count = HITS_TANGENT;
                    n_res.t_first   = w_c1.val;
                    n_res.saturated = w_c1.sat;
                end
                HITS_TWO: begin
                    n_res.hit_count = HITS_TWO;
                    n_res.t_first   = w_c1.val;
                    n_res.t_second  = w_c2.val;
                    n_res.saturated = w_c1.sat | w_c2.sat;
                end
                default: begin
                    n_res.hit_count = HITS_NONE;
                end
            endcase
        end
    end

    assign o_done   = r_o_v;
    assign o_result = r_res;

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.hit_count == HITS_NONE |->
            o_result.t_first == '0 && o_result.t_second == '0 && !o_result.saturated)
        else $error("no-hit word carries parameters");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.degenerate |->
            o_result.hit_count == HITS_NONE && !o_result.saturated)
        else $error("degenerate word reports hits");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.hit_count == HITS_TWO && !o_result.saturated |->
            $signed(o_result.t_first) >= $signed(o_result.t_second))
        else $error("crossings out of order");

    a_tangent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.hit_count == HITS_TANGENT |-> o_result.t_second == '0)
        else $error("tangent word carries second parameter");

endmodule
